@@ hw/rtl/iph_pkg.sv @@
// Shared types and constants for the instruction pair histogram.
package iph_pkg;

	// Pair key: {first kind, second kind, link code}
	localparam int unsigned KIND_W = 8;
	localparam int unsigned LINK_W = 3;
	localparam int unsigned KEY_W  = 2 * KIND_W + LINK_W;
	localparam int unsigned CNT_W  = 64;

	localparam int unsigned TABLE_DEPTH_DEF = 256;

	// Link code bits
	localparam logic [LINK_W-1:0] LINK_SRC1 = 3'd1;
	localparam logic [LINK_W-1:0] LINK_SRC2 = 3'd2;
	localparam logic [LINK_W-1:0] LINK_OVER = 3'd4;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// Control bits of the search token walking the cell row
	typedef struct packed {
		logic vld;   // token present
		logic done;  // an entry matched or was created
		logic app;   // the entry was created by this token
	} tok_ctl_t;

endpackage

@@ hw/rtl/iph_cell.sv @@
// One table entry: key and count, compared against the passing search token.
module iph_cell #(
	parameter int unsigned DEPTH = iph_pkg::TABLE_DEPTH_DEF,
	parameter int unsigned INDEX = 0,
	localparam int unsigned IDX_W  = $clog2(DEPTH),
	localparam int unsigned USED_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [USED_W-1:0] used,
	input  iph_pkg::tok_ctl_t in_ctl,
	input  iph_pkg::key_t     in_key,
	input  logic [IDX_W-1:0]  in_idx,
	input  iph_pkg::cnt_t     in_cnt,
	output iph_pkg::tok_ctl_t out_ctl,
	output iph_pkg::key_t     out_key,
	output logic [IDX_W-1:0]  out_idx,
	output iph_pkg::cnt_t     out_cnt
);

	localparam logic [USED_W-1:0] MY_POS = USED_W'(INDEX);
	localparam logic [IDX_W-1:0]  MY_IDX = IDX_W'(INDEX);

	iph_pkg::key_t     key_q;
	iph_pkg::cnt_t     cnt_q;
	iph_pkg::cnt_t     cnt_inc;
	iph_pkg::tok_ctl_t ctl_q;
	iph_pkg::key_t     tkey_q;
	logic [IDX_W-1:0]  tidx_q;
	iph_pkg::cnt_t     tcnt_q;
	logic              searching;
	logic              hit;
	logic              append;

	// Match an entry in use, or claim the first free one
	assign searching = in_ctl.vld && !in_ctl.done;
	assign hit       = searching && (MY_POS < used) && (key_q == in_key);
	assign append    = searching && (MY_POS == used);
	assign cnt_inc   = cnt_q + iph_pkg::CNT_W'(1);

	// Update the stored entry
	always_ff @(posedge clk) begin
		if (hit) begin
			cnt_q <= cnt_inc;
		end else if (append) begin
			key_q <= in_key;
			cnt_q <= iph_pkg::CNT_W'(1);
		end
	end

	// Hand the token to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.vld  <= in_ctl.vld;
			ctl_q.done <= in_ctl.done || hit || append;
			ctl_q.app  <= in_ctl.app || append;
		end
	end

	always_ff @(posedge clk) begin
		tkey_q <= in_key;
		if (hit) begin
			tidx_q <= MY_IDX;
			tcnt_q <= cnt_inc;
		end else if (append) begin
			tidx_q <= MY_IDX;
			tcnt_q <= iph_pkg::CNT_W'(1);
		end else begin
			tidx_q <= in_idx;
			tcnt_q <= in_cnt;
		end
	end

	assign out_ctl = ctl_q;
	assign out_key = tkey_q;
	assign out_idx = tidx_q;
	assign out_cnt = tcnt_q;

endmodule

@@ hw/rtl/iph_chain.sv @@
// Row of table cells; the search token advances one cell per cycle.
module iph_chain #(
	parameter int unsigned DEPTH = iph_pkg::TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W  = $clog2(DEPTH),
	localparam int unsigned USED_W = $clog2(DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [USED_W-1:0] used,
	input  iph_pkg::tok_ctl_t head_ctl,
	input  iph_pkg::key_t     head_key,
	output iph_pkg::tok_ctl_t tail_ctl,
	output logic [IDX_W-1:0]  tail_idx,
	output iph_pkg::cnt_t     tail_cnt
);

	iph_pkg::tok_ctl_t lnk_ctl [DEPTH+1];
	iph_pkg::key_t     lnk_key [DEPTH+1];
	logic [IDX_W-1:0]  lnk_idx [DEPTH+1];
	iph_pkg::cnt_t     lnk_cnt [DEPTH+1];

	// Fresh token enters with no result yet
	assign lnk_ctl[0] = head_ctl;
	assign lnk_key[0] = head_key;
	assign lnk_idx[0] = '0;
	assign lnk_cnt[0] = '0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		iph_cell #(
			.DEPTH (DEPTH),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.used    (used),
			.in_ctl  (lnk_ctl[i]),
			.in_key  (lnk_key[i]),
			.in_idx  (lnk_idx[i]),
			.in_cnt  (lnk_cnt[i]),
			.out_ctl (lnk_ctl[i+1]),
			.out_key (lnk_key[i+1]),
			.out_idx (lnk_idx[i+1]),
			.out_cnt (lnk_cnt[i+1])
		);
	end

	assign tail_ctl = lnk_ctl[DEPTH];
	assign tail_idx = lnk_idx[DEPTH];
	assign tail_cnt = lnk_cnt[DEPTH];

endmodule

@@ hw/rtl/instruction_pair_histogram.sv @@
// Top level of the instruction pair histogram: pair detection, counters, result register.
//
// Takes one executed instruction per transfer and returns one result per instruction.
// An instruction that does not follow its predecessor skips the table lookup.
// An adjacent pair is looked up by a token that walks the row of TABLE_DEPTH table cells,
// one cell per cycle, and always runs to the end of the row; that walk sets the rate.
// One instruction is in work at a time; the next one is taken while a finished result
// still waits in the output register.
// Table cells need no clearing after reset: only entries below the use count are matched.
module instruction_pair_histogram #(
	parameter int unsigned TABLE_DEPTH = iph_pkg::TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] pc,
	input  logic [3:0]  length,
	input  logic [4:0]  dest_reg,
	input  logic [4:0]  source_reg1,
	input  logic [4:0]  source_reg2,
	input  logic [7:0]  kind,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        pair_seen,
	output logic [2:0]  link_code,
	output logic [7:0]  entry_index,
	output logic [63:0] entry_count,
	output logic        dropped,
	output logic [63:0] total_count,
	output logic [63:0] pair_count,
	output logic [8:0]  distinct_used
);

	localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
	localparam int unsigned USED_W = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]        state_q;
	logic              in_xfer;
	logic              out_load;
	logic              is_pair;
	logic [2:0]        link;
	iph_pkg::key_t     key;

	logic [31:0]       prev_next_q;
	logic [4:0]        prev_dest_q;
	logic [7:0]        prev_kind_q;
	logic              have_prev_q;
	logic [63:0]       total_q;
	logic [63:0]       pairs_q;
	logic [USED_W-1:0] used_q;

	iph_pkg::tok_ctl_t inj_ctl_q;
	iph_pkg::key_t     inj_key_q;
	iph_pkg::tok_ctl_t tail_ctl;
	logic [IDX_W-1:0]  tail_idx;
	iph_pkg::cnt_t     tail_cnt;

	logic              res_pair_q;
	logic [2:0]        res_link_q;
	logic [7:0]        res_idx_q;
	logic [63:0]       res_cnt_q;
	logic              res_drop_q;

	logic              out_valid_q;
	logic              pair_seen_q;
	logic [2:0]        link_code_q;
	logic [7:0]        entry_index_q;
	logic [63:0]       entry_count_q;
	logic              dropped_q;
	logic [63:0]       total_count_q;
	logic [63:0]       pair_count_q;
	logic [8:0]        distinct_used_q;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Detect an adjacent pair and form its link code and key
	assign is_pair = have_prev_q && (prev_next_q == pc);

	always_comb begin
		link = '0;
		if (prev_dest_q != 5'd0) begin
			if (source_reg1 == prev_dest_q) begin
				link = link | iph_pkg::LINK_SRC1;
			end
			if (source_reg2 == prev_dest_q) begin
				link = link | iph_pkg::LINK_SRC2;
			end
			if ((link != 3'd0) && (dest_reg == prev_dest_q)) begin
				link = link | iph_pkg::LINK_OVER;
			end
		end
	end

	assign key = {prev_kind_q, kind, link};

	// Sequence one instruction through lookup and result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_xfer) begin
						state_q <= is_pair ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (tail_ctl.vld) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Track the previous instruction and the running counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_next_q <= '0;
			prev_dest_q <= '0;
			prev_kind_q <= '0;
			have_prev_q <= 1'b0;
			total_q     <= '0;
			pairs_q     <= '0;
			used_q      <= '0;
		end else begin
			if (in_xfer) begin
				prev_next_q <= pc + {28'd0, length};
				prev_dest_q <= dest_reg;
				prev_kind_q <= kind;
				have_prev_q <= 1'b1;
				total_q     <= total_q + 64'd1;
				if (is_pair) begin
					pairs_q <= pairs_q + 64'd1;
				end
			end
			if ((state_q == ST_SCAN) && tail_ctl.vld && tail_ctl.app) begin
				used_q <= used_q + USED_W'(1);
			end
		end
	end

	// Launch the search token for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_ctl_q <= '0;
		end else begin
			inj_ctl_q.vld  <= in_xfer && is_pair;
			inj_ctl_q.done <= 1'b0;
			inj_ctl_q.app  <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			inj_key_q <= key;
		end
	end

	iph_chain #(
		.DEPTH (TABLE_DEPTH)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.used     (used_q),
		.head_ctl (inj_ctl_q),
		.head_key (inj_key_q),
		.tail_ctl (tail_ctl),
		.tail_idx (tail_idx),
		.tail_cnt (tail_cnt)
	);

	// Hold the lookup result until the output register is free
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			res_pair_q <= is_pair;
			res_link_q <= is_pair ? link : 3'd0;
			res_idx_q  <= '0;
			res_cnt_q  <= '0;
			res_drop_q <= 1'b0;
		end else if ((state_q == ST_SCAN) && tail_ctl.vld) begin
			res_idx_q  <= tail_ctl.done ? 8'(tail_idx) : 8'd0;
			res_cnt_q  <= tail_ctl.done ? tail_cnt : 64'd0;
			res_drop_q <= !tail_ctl.done;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pair_seen_q     <= res_pair_q;
			link_code_q     <= res_link_q;
			entry_index_q   <= res_idx_q;
			entry_count_q   <= res_cnt_q;
			dropped_q       <= res_drop_q;
			total_count_q   <= total_q;
			pair_count_q    <= pairs_q;
			distinct_used_q <= 9'(used_q);
		end
	end

	assign out_valid     = out_valid_q;
	assign pair_seen     = pair_seen_q;
	assign link_code     = link_code_q;
	assign entry_index   = entry_index_q;
	assign entry_count   = entry_count_q;
	assign dropped       = dropped_q;
	assign total_count   = total_count_q;
	assign pair_count    = pair_count_q;
	assign distinct_used = distinct_used_q;

	// A token leaves the row only while a lookup is pending
	a_tail_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail_ctl.vld |-> (state_q == ST_SCAN))
		else $error("search token left the cell row outside a lookup");

	// The use count never passes the table depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= USED_W'(TABLE_DEPTH))
		else $error("table use count exceeds depth");

	// The use count only steps up by one
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + USED_W'(1)))
		else $error("table use count changed by other than one");

	// An accepted pair starts a lookup in the next cycle
	a_pair_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && is_pair) |=> (inj_ctl_q.vld && (state_q == ST_SCAN)))
		else $error("pair accepted without launching a lookup");

	// A dropped pair reports no entry
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && dropped_q) |-> ((entry_count_q == 64'd0) && pair_seen_q))
		else $error("dropped pair carries an entry count");

endmodule
